[rtl/pcp_pkg.sv]
package pcp_pkg;

    localparam int COORD_FRAC_BITS = 16;

    localparam logic [31:0]        FOCAL_X_RST  = 32'(64'd500 << COORD_FRAC_BITS);
    localparam logic [31:0]        FOCAL_Y_RST  = 32'(64'd500 << COORD_FRAC_BITS);
    localparam logic signed [31:0] CENTER_X_RST = 32'(64'd320 << COORD_FRAC_BITS);
    localparam logic signed [31:0] CENTER_Y_RST = 32'(64'd240 << COORD_FRAC_BITS);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

    localparam logic [2:0] ACT_W2C = 3'd0;
    localparam logic [2:0] ACT_C2W = 3'd1;
    localparam logic [2:0] ACT_C2P = 3'd2;
    localparam logic [2:0] ACT_P2C = 3'd3;
    localparam logic [2:0] ACT_P2W = 3'd4;
    localparam logic [2:0] ACT_W2P = 3'd5;

    localparam int DIV_STEPS = 64;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic               invalid;
    } t_out;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
    } t_vec;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    } t_qprod;

    typedef struct packed {
        logic signed [30:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    } t_rot;

    // item context carried alongside the divider lanes
    typedef struct packed {
        logic [2:0] action;
        logic       bad;
        logic       neg_a;
        logic       neg_b;
        t_vec       pt;
        t_vec       trans;
        t_quat      quat;
    } t_tag;

    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] nq;
    } t_divst;

    function automatic t_qprod quat_prod(t_quat q);
        t_qprod p;
        p.xx = q.x * q.x;
        p.yy = q.y * q.y;
        p.zz = q.z * q.z;
        p.xy = q.x * q.y;
        p.xz = q.x * q.z;
        p.yz = q.y * q.z;
        p.wx = q.w * q.x;
        p.wy = q.w * q.y;
        p.wz = q.w * q.z;
        return p;
    endfunction

    function automatic logic signed [30:0] clamp_rot(logic signed [34:0] v);
        logic signed [30:0] r;
        if (v > 35'sd536870912) begin
            r = 31'sd536870912;
        end else if (v < -35'sd536870912) begin
            r = -31'sd536870912;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic t_rot rot_from_prod(t_qprod p);
        t_rot              r;
        logic signed [34:0] one;
        one   = 35'sd268435456;
        r.r00 = clamp_rot(one - ((35'(p.yy) + 35'(p.zz)) <<< 1));
        r.r01 = clamp_rot((35'(p.xy) - 35'(p.wz)) <<< 1);
        r.r02 = clamp_rot((35'(p.xz) + 35'(p.wy)) <<< 1);
        r.r10 = clamp_rot((35'(p.xy) + 35'(p.wz)) <<< 1);
        r.r11 = clamp_rot(one - ((35'(p.xx) + 35'(p.zz)) <<< 1));
        r.r12 = clamp_rot((35'(p.yz) - 35'(p.wx)) <<< 1);
        r.r20 = clamp_rot((35'(p.xz) - 35'(p.wy)) <<< 1);
        r.r21 = clamp_rot((35'(p.yz) + 35'(p.wx)) <<< 1);
        r.r22 = clamp_rot(one - ((35'(p.xx) + 35'(p.yy)) <<< 1));
        return r;
    endfunction

    // shift right by 28, round half up
    function automatic logic signed [37:0] round28(logic signed [65:0] acc);
        logic signed [65:0] t;
        t = acc + (66'sd1 <<< 27);
        return 38'(t >>> 28);
    endfunction

    function automatic t_word sat32(logic signed [67:0] v);
        t_word r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // one restoring division step
    function automatic t_divst div_step(t_divst s, logic [31:0] den);
        t_divst      r;
        logic [32:0] trial;
        logic        qbit;
        trial = {s.rem, s.nq[63]};
        if (trial >= {1'b0, den}) begin
            r.rem = 32'(trial - {1'b0, den});
            qbit  = 1'b1;
        end else begin
            r.rem = trial[31:0];
            qbit  = 1'b0;
        end
        r.nq = {s.nq[62:0], qbit};
        return r;
    endfunction

endpackage

[rtl/pcp_div.sv]
module pcp_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [63:0]   i_num_a,
    input  logic [31:0]   i_den_a,
    input  logic [63:0]   i_num_b,
    input  logic [31:0]   i_den_b,
    input  pcp_pkg::t_tag i_tag,
    output logic          o_vld,
    output logic [63:0]   o_quo_a,
    output logic [63:0]   o_quo_b,
    output pcp_pkg::t_tag o_tag
);

    localparam int N = pcp_pkg::DIV_STEPS;

    logic [N-1:0]    r_vld;
    pcp_pkg::t_divst r_st_a  [N];
    pcp_pkg::t_divst r_st_b  [N];
    logic [31:0]     r_den_a [N];
    logic [31:0]     r_den_b [N];
    pcp_pkg::t_tag   r_tag   [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        pcp_pkg::t_divst n_st_a, n_st_b;
        logic [31:0]     n_den_a, n_den_b;
        pcp_pkg::t_tag   n_tag;

        if (k == 0) begin : g_first
            assign n_st_a  = {32'd0, i_num_a};
            assign n_st_b  = {32'd0, i_num_b};
            assign n_den_a = i_den_a;
            assign n_den_b = i_den_b;
            assign n_tag   = i_tag;
        end else begin : g_next
            assign n_st_a  = r_st_a[k-1];
            assign n_st_b  = r_st_b[k-1];
            assign n_den_a = r_den_a[k-1];
            assign n_den_b = r_den_b[k-1];
            assign n_tag   = r_tag[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st_a[k]  <= pcp_pkg::div_step(n_st_a, n_den_a);
                r_st_b[k]  <= pcp_pkg::div_step(n_st_b, n_den_b);
                r_den_a[k] <= n_den_a;
                r_den_b[k] <= n_den_b;
                r_tag[k]   <= n_tag;
            end
        end
    end

    assign o_vld   = r_vld[N-1];
    assign o_quo_a = r_st_a[N-1].nq;
    assign o_quo_b = r_st_b[N-1].nq;
    assign o_tag   = r_tag[N-1];

endmodule

[rtl/pinhole_camera_projection.sv]
// Pinhole camera projection: maps one point per transaction between world, camera and pixel
// frames using the pose in the item and the focal/center registers. Fully pipelined: a new
// transaction is taken every cycle while the output buffer has room. The latency is set
// mostly by the 64-stage restoring divider (one quotient bit per stage), plus eight stages
// ahead of it for the forward rotation and numerator multiply and six behind it for sign,
// centering and the inverse rotation. A two-entry output buffer decouples the sides; input
// stalls only while both entries are occupied. Zero depth or zero focal length returns
// zeros with invalid set; actions 6 and 7 return zeros. Registers may be rewritten only when
// the block holds no transactions.
module pinhole_camera_projection (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pcp_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pcp_pkg::t_out                   o_out,
    input  logic                            i_cfg_we,
    input  logic [pcp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);

    logic [31:0]        r_focal_x, r_focal_y;
    logic signed [31:0] r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= pcp_pkg::FOCAL_X_RST;
            r_focal_y  <= pcp_pkg::FOCAL_Y_RST;
            r_center_x <= pcp_pkg::CENTER_X_RST;
            r_center_y <= pcp_pkg::CENTER_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcp_pkg::REG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                pcp_pkg::REG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                pcp_pkg::REG_CENTER_X: r_center_x <= i_cfg_data;
                pcp_pkg::REG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [1:0] r_cnt;
    logic       w_en, w_push, w_pop;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    // front: input, quaternion products, matrix, forward multiply, forward sum,
    // divider setup, numerator multiply, magnitudes
    logic [7:0]           r_vld_f;
    pcp_pkg::t_in         r_s0, r_s1_in, r_s2_in, r_s3_in, r_s4_in;
    pcp_pkg::t_qprod      r_s1_qp;
    pcp_pkg::t_rot        r_s2_rot;
    logic signed [62:0]   r_s3_m [9];
    pcp_pkg::t_vec        r_s4_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= '0;
        end else if (w_en) begin
            r_vld_f <= {r_vld_f[6:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0     <= i_in;
            r_s1_in  <= r_s0;
            r_s1_qp  <= pcp_pkg::quat_prod({r_s0.quat_w, r_s0.quat_x, r_s0.quat_y, r_s0.quat_z});
            r_s2_in  <= r_s1_in;
            r_s2_rot <= pcp_pkg::rot_from_prod(r_s1_qp);
            r_s3_in  <= r_s2_in;
            r_s3_m[0] <= r_s2_rot.r00 * r_s2_in.coord_a;
            r_s3_m[1] <= r_s2_rot.r01 * r_s2_in.coord_b;
            r_s3_m[2] <= r_s2_rot.r02 * r_s2_in.coord_c;
            r_s3_m[3] <= r_s2_rot.r10 * r_s2_in.coord_a;
            r_s3_m[4] <= r_s2_rot.r11 * r_s2_in.coord_b;
            r_s3_m[5] <= r_s2_rot.r12 * r_s2_in.coord_c;
            r_s3_m[6] <= r_s2_rot.r20 * r_s2_in.coord_a;
            r_s3_m[7] <= r_s2_rot.r21 * r_s2_in.coord_b;
            r_s3_m[8] <= r_s2_rot.r22 * r_s2_in.coord_c;
            r_s4_in  <= r_s3_in;
            r_s4_fwd.a <= pcp_pkg::sat32(68'(pcp_pkg::round28(66'(r_s3_m[0]) + 66'(r_s3_m[1])
                          + 66'(r_s3_m[2]))) + 68'(r_s3_in.trans_x));
            r_s4_fwd.b <= pcp_pkg::sat32(68'(pcp_pkg::round28(66'(r_s3_m[3]) + 66'(r_s3_m[4])
                          + 66'(r_s3_m[5]))) + 68'(r_s3_in.trans_y));
            r_s4_fwd.c <= pcp_pkg::sat32(68'(pcp_pkg::round28(66'(r_s3_m[6]) + 66'(r_s3_m[7])
                          + 66'(r_s3_m[8]))) + 68'(r_s3_in.trans_z));
        end
    end

    // divider setup: pixel mode divides focal*coord by z, camera mode divides
    // (pixel - center)*depth by focal
    logic               w_pix, w_cam;
    pcp_pkg::t_vec      w_src;
    logic signed [32:0] w_ma_a, w_ma_b, w_den_a, w_den_b;
    logic signed [31:0] w_mb_a, w_mb_b;
    pcp_pkg::t_tag      w_s5_tag;

    always_comb begin
        w_pix = (r_s4_in.action == pcp_pkg::ACT_C2P) || (r_s4_in.action == pcp_pkg::ACT_W2P);
        w_cam = (r_s4_in.action == pcp_pkg::ACT_P2C) || (r_s4_in.action == pcp_pkg::ACT_P2W);
        if (r_s4_in.action == pcp_pkg::ACT_C2P) begin
            w_src = {r_s4_in.coord_a, r_s4_in.coord_b, r_s4_in.coord_c};
        end else begin
            w_src = r_s4_fwd;
        end
        if (w_pix) begin
            w_ma_a  = $signed({1'b0, r_focal_x});
            w_ma_b  = $signed({1'b0, r_focal_y});
            w_mb_a  = w_src.a;
            w_mb_b  = w_src.b;
            w_den_a = 33'(w_src.c);
            w_den_b = 33'(w_src.c);
        end else begin
            w_ma_a  = 33'(r_s4_in.coord_a) - 33'(r_center_x);
            w_ma_b  = 33'(r_s4_in.coord_b) - 33'(r_center_y);
            w_mb_a  = r_s4_in.coord_c;
            w_mb_b  = r_s4_in.coord_c;
            w_den_a = $signed({1'b0, r_focal_x});
            w_den_b = $signed({1'b0, r_focal_y});
        end
        w_s5_tag.action = r_s4_in.action;
        w_s5_tag.bad    = (w_pix && (w_src.c == 32'sd0))
                       || (w_cam && ((r_focal_x == 32'd0) || (r_focal_y == 32'd0)));
        w_s5_tag.neg_a  = 1'b0;
        w_s5_tag.neg_b  = 1'b0;
        w_s5_tag.trans  = {r_s4_in.trans_x, r_s4_in.trans_y, r_s4_in.trans_z};
        w_s5_tag.quat   = {r_s4_in.quat_w, r_s4_in.quat_x, r_s4_in.quat_y, r_s4_in.quat_z};
        if (r_s4_in.action == pcp_pkg::ACT_W2C) begin
            w_s5_tag.pt = r_s4_fwd;
        end else if (r_s4_in.action == pcp_pkg::ACT_C2W) begin
            w_s5_tag.pt = {r_s4_in.coord_a, r_s4_in.coord_b, r_s4_in.coord_c};
        end else if (w_cam) begin
            w_s5_tag.pt = {32'sd0, 32'sd0, r_s4_in.coord_c};
        end else begin
            w_s5_tag.pt = '0;
        end
    end

    logic signed [32:0] r_s5_ma_a, r_s5_ma_b, r_s5_den_a, r_s5_den_b;
    logic signed [31:0] r_s5_mb_a, r_s5_mb_b;
    pcp_pkg::t_tag      r_s5_tag, r_s6_tag, r_s7_tag;
    logic signed [64:0] r_s6_num_a, r_s6_num_b;
    logic               r_s6_dneg_a, r_s6_dneg_b;
    logic [31:0]        r_s6_dmag_a, r_s6_dmag_b, r_s7_dmag_a, r_s7_dmag_b;
    logic [63:0]        r_s7_nmag_a, r_s7_nmag_b;
    pcp_pkg::t_tag      n_s7_tag;

    // quotient signs ride in the tag
    always_comb begin
        n_s7_tag       = r_s6_tag;
        n_s7_tag.neg_a = r_s6_num_a[64] ^ r_s6_dneg_a;
        n_s7_tag.neg_b = r_s6_num_b[64] ^ r_s6_dneg_b;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_ma_a   <= w_ma_a;
            r_s5_ma_b   <= w_ma_b;
            r_s5_mb_a   <= w_mb_a;
            r_s5_mb_b   <= w_mb_b;
            r_s5_den_a  <= w_den_a;
            r_s5_den_b  <= w_den_b;
            r_s5_tag    <= w_s5_tag;
            r_s6_num_a  <= r_s5_ma_a * r_s5_mb_a;
            r_s6_num_b  <= r_s5_ma_b * r_s5_mb_b;
            r_s6_dneg_a <= r_s5_den_a[32];
            r_s6_dneg_b <= r_s5_den_b[32];
            r_s6_dmag_a <= r_s5_den_a[32] ? 32'(-r_s5_den_a) : r_s5_den_a[31:0];
            r_s6_dmag_b <= r_s5_den_b[32] ? 32'(-r_s5_den_b) : r_s5_den_b[31:0];
            r_s6_tag    <= r_s5_tag;
            r_s7_nmag_a <= r_s6_num_a[64] ? 64'(-r_s6_num_a) : r_s6_num_a[63:0];
            r_s7_nmag_b <= r_s6_num_b[64] ? 64'(-r_s6_num_b) : r_s6_num_b[63:0];
            r_s7_dmag_a <= r_s6_dmag_a;
            r_s7_dmag_b <= r_s6_dmag_b;
            r_s7_tag    <= n_s7_tag;
        end
    end

    logic          w_div_vld;
    logic [63:0]   w_quo_a, w_quo_b;
    pcp_pkg::t_tag w_div_tag;

    pcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld_f[7]),
        .i_num_a (r_s7_nmag_a),
        .i_den_a (r_s7_dmag_a),
        .i_num_b (r_s7_nmag_b),
        .i_den_b (r_s7_dmag_b),
        .i_tag   (r_s7_tag),
        .o_vld   (w_div_vld),
        .o_quo_a (w_quo_a),
        .o_quo_b (w_quo_b),
        .o_tag   (w_div_tag)
    );

    // back: sign, centering, inverse rotation
    logic [5:0]         r_vld_b;
    logic signed [64:0] r_p1_qa, r_p1_qb;
    pcp_pkg::t_tag      r_p1_tag, r_p2_tag, r_i1_tag, r_i2_tag, r_i3_tag;
    pcp_pkg::t_qprod    r_i1_qp;
    pcp_pkg::t_rot      r_i2_rot;
    logic signed [32:0] r_i1_d [3];
    logic signed [32:0] r_i2_d [3];
    logic signed [63:0] r_i3_m [9];
    pcp_pkg::t_out      r_i4_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= '0;
        end else if (w_en) begin
            r_vld_b <= {r_vld_b[4:0], w_div_vld};
        end
    end

    logic               w_p_pix, w_p_cam;
    logic signed [64:0] w_ca, w_cb;
    pcp_pkg::t_tag      w_p2_tag;

    // pixel quotients are clamped to +-2^40 before the center is added
    always_comb begin
        w_p_pix = (r_p1_tag.action == pcp_pkg::ACT_C2P) || (r_p1_tag.action == pcp_pkg::ACT_W2P);
        w_p_cam = (r_p1_tag.action == pcp_pkg::ACT_P2C) || (r_p1_tag.action == pcp_pkg::ACT_P2W);
        if (r_p1_qa > 65'sd1099511627776) begin
            w_ca = 65'sd1099511627776;
        end else if (r_p1_qa < -65'sd1099511627776) begin
            w_ca = -65'sd1099511627776;
        end else begin
            w_ca = r_p1_qa;
        end
        if (r_p1_qb > 65'sd1099511627776) begin
            w_cb = 65'sd1099511627776;
        end else if (r_p1_qb < -65'sd1099511627776) begin
            w_cb = -65'sd1099511627776;
        end else begin
            w_cb = r_p1_qb;
        end
        w_p2_tag = r_p1_tag;
        if (w_p_pix) begin
            w_p2_tag.pt.a = pcp_pkg::sat32(68'(w_ca) + 68'(r_center_x));
            w_p2_tag.pt.b = pcp_pkg::sat32(68'(w_cb) + 68'(r_center_y));
            w_p2_tag.pt.c = 32'sd0;
        end else if (w_p_cam) begin
            w_p2_tag.pt.a = pcp_pkg::sat32(68'(r_p1_qa));
            w_p2_tag.pt.b = pcp_pkg::sat32(68'(r_p1_qb));
        end
    end

    pcp_pkg::t_vec w_inv;
    pcp_pkg::t_out n_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_qa   <= w_div_tag.neg_a ? -$signed({1'b0, w_quo_a}) : $signed({1'b0, w_quo_a});
            r_p1_qb   <= w_div_tag.neg_b ? -$signed({1'b0, w_quo_b}) : $signed({1'b0, w_quo_b});
            r_p1_tag  <= w_div_tag;
            r_p2_tag  <= w_p2_tag;
            r_i1_qp   <= pcp_pkg::quat_prod(r_p2_tag.quat);
            r_i1_d[0] <= 33'(r_p2_tag.pt.a) - 33'(r_p2_tag.trans.a);
            r_i1_d[1] <= 33'(r_p2_tag.pt.b) - 33'(r_p2_tag.trans.b);
            r_i1_d[2] <= 33'(r_p2_tag.pt.c) - 33'(r_p2_tag.trans.c);
            r_i1_tag  <= r_p2_tag;
            r_i2_rot  <= pcp_pkg::rot_from_prod(r_i1_qp);
            r_i2_d    <= r_i1_d;
            r_i2_tag  <= r_i1_tag;
            // transposed matrix times (p - t)
            r_i3_m[0] <= r_i2_rot.r00 * r_i2_d[0];
            r_i3_m[1] <= r_i2_rot.r10 * r_i2_d[1];
            r_i3_m[2] <= r_i2_rot.r20 * r_i2_d[2];
            r_i3_m[3] <= r_i2_rot.r01 * r_i2_d[0];
            r_i3_m[4] <= r_i2_rot.r11 * r_i2_d[1];
            r_i3_m[5] <= r_i2_rot.r21 * r_i2_d[2];
            r_i3_m[6] <= r_i2_rot.r02 * r_i2_d[0];
            r_i3_m[7] <= r_i2_rot.r12 * r_i2_d[1];
            r_i3_m[8] <= r_i2_rot.r22 * r_i2_d[2];
            r_i3_tag  <= r_i2_tag;
            r_i4_out  <= n_out;
        end
    end

    always_comb begin
        w_inv.a = pcp_pkg::sat32(68'(pcp_pkg::round28(66'(r_i3_m[0]) + 66'(r_i3_m[1])
                  + 66'(r_i3_m[2]))));
        w_inv.b = pcp_pkg::sat32(68'(pcp_pkg::round28(66'(r_i3_m[3]) + 66'(r_i3_m[4])
                  + 66'(r_i3_m[5]))));
        w_inv.c = pcp_pkg::sat32(68'(pcp_pkg::round28(66'(r_i3_m[6]) + 66'(r_i3_m[7])
                  + 66'(r_i3_m[8]))));
        if (r_i3_tag.bad) begin
            n_out = '0;
            n_out.invalid = 1'b1;
        end else if ((r_i3_tag.action == pcp_pkg::ACT_C2W)
                  || (r_i3_tag.action == pcp_pkg::ACT_P2W)) begin
            n_out = {w_inv.a, w_inv.b, w_inv.c, 1'b0};
        end else begin
            n_out = {r_i3_tag.pt.a, r_i3_tag.pt.b, r_i3_tag.pt.c, 1'b0};
        end
    end

    // two-entry output buffer
    pcp_pkg::t_out r_head, r_skid;

    assign w_push      = w_en && r_vld_b[5];
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && ((r_cnt == 2'd0) || w_pop)) begin
            r_head <= r_i4_out;
        end else if (w_pop && (r_cnt == 2'd2)) begin
            r_head <= r_skid;
        end
        if (w_push && !w_pop && (r_cnt == 2'd1)) begin
            r_skid <= r_i4_out;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.invalid) |->
        (o_out.out_a == 32'sd0) && (o_out.out_b == 32'sd0) && (o_out.out_c == 32'sd0))
        else $error("invalid result carries nonzero coordinates");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == 2'($past(r_cnt) - 2'd1)))
        else $error("output buffer count did not drop on pop");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop && (r_cnt == 2'd1)) |=>
        (r_cnt == 2'd2) && (r_skid == $past(r_i4_out)) && !o_in_ready)
        else $error("skid entry not captured");
`endif

endmodule

[tb/pinhole_camera_projection_test.sv]
module pinhole_camera_projection_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          STALL_LIMIT  = 5000;
    localparam logic signed [15:0] Q_ONE = 16'sd16384;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    pcp_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_ready;
    pcp_pkg::t_out o_out;
    logic          i_cfg_we;
    logic [pcp_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]   i_cfg_data;

    pinhole_camera_projection dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // camera intrinsics as seen by the predictor
    longint focal_x_q, focal_y_q, center_x_q, center_y_q;

    pcp_pkg::t_out pending_points[$];
    int     errors;
    int     points_sent;
    int     points_checked;
    int     invalid_seen;
    int     hold_len;
    int     stall_pct;
    int     idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_word(longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic void rotate_fwd(input longint p[3], input longint t[3],
                                       input longint r[3][3], output longint o[3]);
        longint acc;
        for (int i = 0; i < 3; i++) begin
            acc  = r[i][0] * p[0] + r[i][1] * p[1] + r[i][2] * p[2];
            o[i] = sat_word(((acc + 134217728) >>> 28) + t[i]);
        end
    endfunction

    function automatic void rotate_inv(input longint p[3], input longint t[3],
                                       input longint r[3][3], output longint o[3]);
        longint acc;
        longint d[3];
        for (int i = 0; i < 3; i++) d[i] = p[i] - t[i];
        for (int i = 0; i < 3; i++) begin
            acc  = r[0][i] * d[0] + r[1][i] * d[1] + r[2][i] * d[2];
            o[i] = sat_word((acc + 134217728) >>> 28);
        end
    endfunction

    function automatic bit cam_to_pixel(input longint p[3], output longint o[3]);
        longint lim;
        lim = 64'sd1 <<< 40;
        o = '{0, 0, 0};
        if (p[2] == 0) return 1'b0;
        o[0] = sat_word(clip((focal_x_q * p[0]) / p[2], -lim, lim) + center_x_q);
        o[1] = sat_word(clip((focal_y_q * p[1]) / p[2], -lim, lim) + center_y_q);
        return 1'b1;
    endfunction

    function automatic bit pixel_to_cam(input longint p[3], output longint o[3]);
        o = '{0, 0, 0};
        if (focal_x_q == 0 || focal_y_q == 0) return 1'b0;
        o[0] = sat_word(((p[0] - center_x_q) * p[2]) / focal_x_q);
        o[1] = sat_word(((p[1] - center_y_q) * p[2]) / focal_y_q);
        o[2] = p[2];
        return 1'b1;
    endfunction

    function automatic pcp_pkg::t_out project_point(pcp_pkg::t_in x);
        longint p[3], t[3], mid[3], o[3];
        longint r[3][3];
        longint w, qx, qy, qz, one, lim;
        bit     ok;
        pcp_pkg::t_out res;
        p   = '{longint'(x.coord_a), longint'(x.coord_b), longint'(x.coord_c)};
        t   = '{longint'(x.trans_x), longint'(x.trans_y), longint'(x.trans_z)};
        w   = x.quat_w;
        qx  = x.quat_x;
        qy  = x.quat_y;
        qz  = x.quat_z;
        one = 64'sd1 <<< 28;
        lim = 64'sd1 <<< 29;
        r[0][0] = one - 2 * (qy * qy + qz * qz);
        r[0][1] = 2 * (qx * qy - w * qz);
        r[0][2] = 2 * (qx * qz + w * qy);
        r[1][0] = 2 * (qx * qy + w * qz);
        r[1][1] = one - 2 * (qx * qx + qz * qz);
        r[1][2] = 2 * (qy * qz - w * qx);
        r[2][0] = 2 * (qx * qz - w * qy);
        r[2][1] = 2 * (qy * qz + w * qx);
        r[2][2] = one - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i][j] = clip(r[i][j], -lim, lim);
        o  = '{0, 0, 0};
        ok = 1'b1;
        case (x.action)
            pcp_pkg::ACT_W2C: rotate_fwd(p, t, r, o);
            pcp_pkg::ACT_C2W: rotate_inv(p, t, r, o);
            pcp_pkg::ACT_C2P: ok = cam_to_pixel(p, o);
            pcp_pkg::ACT_P2C: ok = pixel_to_cam(p, o);
            pcp_pkg::ACT_P2W: begin
                ok = pixel_to_cam(p, mid);
                if (ok) rotate_inv(mid, t, r, o);
            end
            pcp_pkg::ACT_W2P: begin
                rotate_fwd(p, t, r, mid);
                ok = cam_to_pixel(mid, o);
            end
            default: ;
        endcase
        if (!ok) o = '{0, 0, 0};
        res.out_a   = o[0][31:0];
        res.out_b   = o[1][31:0];
        res.out_c   = o[2][31:0];
        res.invalid = !ok;
        return res;
    endfunction

    // input side: record what each accepted transaction should produce
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_points.push_back(project_point(i_in));
            points_sent++;
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge i_clk) begin
        pcp_pkg::t_out exp_pt;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                errors++;
            end else begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (o_out.invalid) invalid_seen++;
                if (o_out.out_a !== exp_pt.out_a) begin
                    $display("%0t: out_a exp %h got %h", $time, exp_pt.out_a, o_out.out_a);
                    errors++;
                end
                if (o_out.out_b !== exp_pt.out_b) begin
                    $display("%0t: out_b exp %h got %h", $time, exp_pt.out_b, o_out.out_b);
                    errors++;
                end
                if (o_out.out_c !== exp_pt.out_c) begin
                    $display("%0t: out_c exp %h got %h", $time, exp_pt.out_c, o_out.out_c);
                    errors++;
                end
                if (o_out.invalid !== exp_pt.invalid) begin
                    $display("%0t: invalid exp %b got %b", $time, exp_pt.invalid,
                             o_out.invalid);
                    errors++;
                end
            end
        end
    end

    // receiver: stall pattern drifts, long hold on request
    initial begin
        int held;
        int dwell;
        held = 0;
        dwell = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                held = hold_len;
                hold_len = 0;
            end
            if (dwell == 0) begin
                dwell = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            dwell--;
            if (held > 0) begin
                held--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    int burst_left;

    task automatic send_point(pcp_pkg::t_in x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pcp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pcp_pkg::REG_FOCAL_X:  focal_x_q  = longint'({32'b0, val});
            pcp_pkg::REG_FOCAL_Y:  focal_y_q  = longint'({32'b0, val});
            pcp_pkg::REG_CENTER_X: center_x_q = longint'(signed'(val));
            default:               center_y_q = longint'(signed'(val));
        endcase
    endtask

    task automatic set_intrinsics(logic [31:0] fx, logic [31:0] fy,
                                  logic [31:0] cx, logic [31:0] cy);
        wait_idle();
        write_reg(pcp_pkg::REG_FOCAL_X, fx);
        write_reg(pcp_pkg::REG_FOCAL_Y, fy);
        write_reg(pcp_pkg::REG_CENTER_X, cx);
        write_reg(pcp_pkg::REG_CENTER_Y, cy);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            3:       return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return 32'($signed($urandom_range(0, 1 << 24)));
        endcase
    endfunction

    function automatic logic [15:0] rand_quat_part();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom());
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 20000)) - 10000);
        endcase
    endfunction

    function automatic pcp_pkg::t_in rand_point();
        pcp_pkg::t_in x;
        x.action  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
        x.coord_a = rand_coord();
        x.coord_b = rand_coord();
        x.coord_c = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_coord();
        if ($urandom_range(0, 2) == 0) begin
            // identity rotation
            x.quat_w = Q_ONE;
            x.quat_x = 16'sd0;
            x.quat_y = 16'sd0;
            x.quat_z = 16'sd0;
        end else begin
            x.quat_w = rand_quat_part();
            x.quat_x = rand_quat_part();
            x.quat_y = rand_quat_part();
            x.quat_z = rand_quat_part();
        end
        x.trans_x = rand_coord();
        x.trans_y = rand_coord();
        x.trans_z = rand_coord();
        return x;
    endfunction

    function automatic pcp_pkg::t_in make_point(logic [2:0] act, pcp_pkg::t_word a,
                                                pcp_pkg::t_word b, pcp_pkg::t_word c);
        pcp_pkg::t_in x;
        x = '0;
        x.action  = act;
        x.coord_a = a;
        x.coord_b = b;
        x.coord_c = c;
        x.quat_w  = Q_ONE;
        return x;
    endfunction

    task automatic test_each_action();
        pcp_pkg::t_in x;
        for (int a = 0; a < 8; a++) begin
            x = make_point(3'(a), 32'sd65536, -32'sd131072, 32'sd655360);
            x.quat_w  = 16'sd11585;
            x.quat_z  = 16'sd11585;
            x.trans_x = 32'sd1000;
            x.trans_z = -32'sd65536;
            send_point(x);
        end
    endtask

    task automatic test_field_extremes();
        pcp_pkg::t_in x;
        x = make_point(pcp_pkg::ACT_W2C, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        x.trans_x = 32'sh7FFFFFFF;
        x.trans_y = 32'sh80000000;
        send_point(x);
        x = make_point(pcp_pkg::ACT_C2W, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        x.quat_w = 16'sh7FFF; x.quat_x = 16'sh8000; x.quat_y = 16'sh7FFF; x.quat_z = 16'sh8000;
        x.trans_z = 32'sh7FFFFFFF;
        send_point(x);
        send_point(make_point(pcp_pkg::ACT_C2P, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1));
        send_point(make_point(pcp_pkg::ACT_C2P, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1));
        send_point(make_point(pcp_pkg::ACT_P2C, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
        send_point(make_point(pcp_pkg::ACT_P2W, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
        send_point(make_point(pcp_pkg::ACT_W2P, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    endtask

    task automatic test_special_cases();
        pcp_pkg::t_in x;
        // zero depth on the camera-side projection
        send_point(make_point(pcp_pkg::ACT_C2P, 32'sd65536, 32'sd65536, 32'sd0));
        // world point landing on the camera plane
        x = make_point(pcp_pkg::ACT_W2P, 32'sd65536, 32'sd65536, 32'sd327680);
        x.trans_z = -32'sd327680;
        send_point(x);
        // non-unit quaternion, rotation entries clamp
        x = make_point(pcp_pkg::ACT_W2C, 32'sd65536, 32'sd65536, 32'sd65536);
        x.quat_w = 16'sh7FFF; x.quat_x = 16'sh7FFF; x.quat_y = 16'sh7FFF; x.quat_z = 16'sh7FFF;
        send_point(x);
        x.quat_w = 16'sd0; x.quat_x = 16'sd0; x.quat_y = 16'sd0; x.quat_z = 16'sd0;
        send_point(x);
        send_point(make_point(ACT_UNDEF_LO, 32'sd5, 32'sd6, 32'sd7));
        send_point(make_point(ACT_UNDEF_HI, 32'sd5, 32'sd6, 32'sd0));
        // zero focal length on back-projection
        set_intrinsics(32'd0, pcp_pkg::FOCAL_Y_RST, pcp_pkg::CENTER_X_RST,
                       pcp_pkg::CENTER_Y_RST);
        send_point(make_point(pcp_pkg::ACT_P2C, 32'sd65536, 32'sd65536, 32'sd65536));
        send_point(make_point(pcp_pkg::ACT_P2W, 32'sd65536, 32'sd65536, 32'sd65536));
        set_intrinsics(pcp_pkg::FOCAL_X_RST, 32'd0, pcp_pkg::CENTER_X_RST,
                       pcp_pkg::CENTER_Y_RST);
        send_point(make_point(pcp_pkg::ACT_P2C, 32'sd65536, 32'sd65536, 32'sd65536));
        send_point(make_point(pcp_pkg::ACT_C2P, 32'sd65536, 32'sd65536, 32'sd65536));
    endtask

    task automatic test_random_intrinsics();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_intrinsics(pcp_pkg::FOCAL_X_RST, pcp_pkg::FOCAL_Y_RST,
                                  pcp_pkg::CENTER_X_RST, pcp_pkg::CENTER_Y_RST);
                1: set_intrinsics(32'd1, 32'd1, 32'h80000000, 32'h7FFFFFFF);
                2: set_intrinsics(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000);
                3: set_intrinsics($urandom_range(1, 32'h00FFFFFF), $urandom(), $urandom(),
                                  $urandom());
                4: set_intrinsics($urandom(), $urandom_range(1, 1 << 20), 32'd0, 32'd0);
                default: set_intrinsics($urandom_range(1 << 16, 1 << 26),
                                        $urandom_range(1 << 16, 1 << 26),
                                        $urandom_range(0, 1 << 26),
                                        $urandom_range(0, 1 << 26));
            endcase
            repeat (270) send_point(rand_point());
        end
    endtask

    task automatic test_output_hold();
        wait_idle();
        hold_len = 600;
        repeat (120) send_point(rand_point());
    endtask

    initial begin
        errors         = 0;
        points_sent    = 0;
        points_checked = 0;
        invalid_seen   = 0;
        hold_len       = 0;
        stall_pct      = 0;
        burst_left     = 0;
        focal_x_q      = longint'({32'b0, pcp_pkg::FOCAL_X_RST});
        focal_y_q      = longint'({32'b0, pcp_pkg::FOCAL_Y_RST});
        center_x_q     = longint'(pcp_pkg::CENTER_X_RST);
        center_y_q     = longint'(pcp_pkg::CENTER_Y_RST);
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_each_action();
        test_field_extremes();
        test_special_cases();
        test_random_intrinsics();
        test_output_hold();

        wait_idle();
        $display("sent %0d points, checked %0d results, %0d flagged invalid",
                 points_sent, points_checked, invalid_seen);
        $display("covered all actions, zero depth/focal, clamped rotations, 6 intrinsic sets");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pcp_pkg.sv
rtl/pcp_div.sv
rtl/pinhole_camera_projection.sv
tb/pinhole_camera_projection_test.sv
